/* rtl/core/hcg_pkg.sv */
// ----------------------------------------------------------------------------
// hcg_pkg
// Shared types and constants of the hot/cold embedding gather block.
// ----------------------------------------------------------------------------
`default_nettype none

package hcg_pkg;

  // Default sizes of the stores
  localparam int TABLE_ROWS_DEF  = 1024;
  localparam int HOT_ROWS_DEF    = 256;
  localparam int COLD_BLOCKS_DEF = 64;
  localparam int MAX_DIM_DEF     = 64;

  // Largest number of items a single gather emits
  localparam int RESULT_CAP = 64;

  // Nibble layout of cold block bytes
  localparam int NIB_BITS = 4;

  // Item kinds
  typedef enum logic [2:0] {
    K_GATHER = 3'd0,
    K_MAP    = 3'd1,
    K_HOT    = 3'd2,
    K_COLD   = 3'd3,
    K_WORD   = 3'd4
  } kind_t;

  // Result source codes
  typedef enum logic [1:0] {
    SRC_COPY  = 2'd0,
    SRC_HOT   = 2'd1,
    SRC_COLD  = 2'd2,
    SRC_RANGE = 2'd3
  } src_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_LARGE    = 3'd0;
  localparam logic [2:0] CFG_HSCALE   = 3'd1;
  localparam logic [2:0] CFG_HOFFSET  = 3'd2;
  localparam logic [2:0] CFG_CSCALE   = 3'd3;
  localparam logic [2:0] CFG_COFFSET  = 3'd4;
  localparam logic [2:0] CFG_RPB      = 3'd5;
  localparam logic [2:0] CFG_DIMS     = 3'd6;

  // Store write strobes and data
  typedef struct packed {
    logic        map_we;
    logic        hot_we;
    logic        cold_we;
    logic        full_we;
    logic [8:0]  slot;
    logic [9:0]  rank;
    logic [31:0] data;
  } wr_t;

endpackage

`default_nettype wire

/* rtl/core/hot_cold_embedding_gather_nibble.sv */
// ----------------------------------------------------------------------------
// hot_cold_embedding_gather_nibble
// Embedding table with load items and dequantizing gathers.
// ----------------------------------------------------------------------------
// Load items (map, hot byte, cold byte, fp32 word) are taken while idle. A
// gather reads the row map, divides the cold rank by rows_per_block bit by
// bit, then emits one item per dimension in use: from the fp32 copy path,
// as a zero result, or through the 9-stage multiply/add unit, and each
// item waits while the consumer stalls. A gather is done before the next
// item is taken. The stores are not cleared at reset; entries must be
// written before read.
`default_nettype none

module hot_cold_embedding_gather_nibble #(
  parameter int TABLE_ROWS  = hcg_pkg::TABLE_ROWS_DEF,
  parameter int HOT_ROWS    = hcg_pkg::HOT_ROWS_DEF,
  parameter int COLD_BLOCKS = hcg_pkg::COLD_BLOCKS_DEF,
  parameter int MAX_DIM     = hcg_pkg::MAX_DIM_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [2:0]        in_kind,
  input  wire  [9:0]        in_row_index,
  input  wire signed [8:0]  in_hot_slot,
  input  wire  [9:0]        in_cold_position,
  input  wire  [5:0]        in_block_number,
  input  wire  [5:0]        in_element,
  input  wire  [31:0]       in_write_data,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [31:0]       out_element_value,
  output logic [5:0]        out_element_number,
  output logic [1:0]        out_source,
  output logic              out_last,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  [2:0]        cfg_index,
  input  wire  [31:0]       cfg_data
);
  import hcg_pkg::*;

  localparam int HALF  = MAX_DIM / 2;
  localparam int HOT_D = HOT_ROWS * MAX_DIM;
  localparam int CLD_D = COLD_BLOCKS * HALF;
  localparam int FUL_D = TABLE_ROWS * MAX_DIM;
  localparam int RW = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int HW = (HOT_D > 1) ? $clog2(HOT_D) : 1;
  localparam int CW = (CLD_D > 1) ? $clog2(CLD_D) : 1;
  localparam int FW = (FUL_D > 1) ? $clog2(FUL_D) : 1;
  localparam logic [6:0] DTOP = 7'(((MAX_DIM < RESULT_CAP) ? MAX_DIM : RESULT_CAP) & ~1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MAP  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_ELEM = 7'b0001000,
    S_DATA = 7'b0010000,
    S_CALC = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic        large_r;
  logic [31:0] hscale_r, hoff_r, cscale_r, coff_r;
  logic [10:0] rpb_r;
  logic [6:0]  dims_cfg_r;

  // Gather context
  logic [9:0]  row_r;
  logic        row_ok_r, quant_r, hot_r, slot_ok_r;
  logic [8:0]  map_r;
  logic [9:0]  rem_r, quo_r;
  logic [3:0]  cnt_r;
  logic [6:0]  dims_r;
  logic [5:0]  d_r;
  logic [31:0] val_r;

  logic [8:0]  map_q;
  logic [9:0]  rank_q;
  logic [7:0]  hot_q, cold_q;
  logic [31:0] full_q;

  wr_t         wr;
  logic        in_acc, out_acc, fpu_start, fpu_done, blk_ok, row_ok_in;
  logic [7:0]  fpu_code;
  logic [31:0] fpu_scale, fpu_off, fpu_res;
  logic [6:0]  dims_eff;
  logic [10:0] rpb_eff, div_t;
  logic [8:0]  map_eff;
  logic [9:0]  rank_eff;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      large_r    <= 1'b0;
      hscale_r   <= 32'h3F80_0000;
      hoff_r     <= 32'd0;
      cscale_r   <= 32'h3F80_0000;
      coff_r     <= 32'd0;
      rpb_r      <= 11'd1;
      dims_cfg_r <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LARGE:   large_r    <= cfg_data[0];
        CFG_HSCALE:  hscale_r   <= cfg_data;
        CFG_HOFFSET: hoff_r     <= cfg_data;
        CFG_CSCALE:  cscale_r   <= cfg_data;
        CFG_COFFSET: coff_r     <= cfg_data;
        CFG_RPB:     rpb_r      <= cfg_data[10:0];
        CFG_DIMS:    dims_cfg_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Clamp dimension count, guard the divisor
  always_comb begin
    dims_eff = dims_cfg_r & 7'h7E;
    if (dims_eff < 7'd2) dims_eff = 7'd2;
    if (dims_eff > DTOP) dims_eff = DTOP;
    rpb_eff = (rpb_r == 11'd0) ? 11'd1 : rpb_r;
  end

  // Decode load items into store writes
  assign row_ok_in = 32'(in_row_index) < TABLE_ROWS;
  always_comb begin
    wr.map_we  = in_acc && (in_kind == K_MAP) && row_ok_in;
    wr.hot_we  = in_acc && (in_kind == K_HOT) && !in_hot_slot[8]
                 && (32'(in_hot_slot[7:0]) < HOT_ROWS) && (32'(in_element) < MAX_DIM);
    wr.cold_we = in_acc && (in_kind == K_COLD) && (32'(in_block_number) < COLD_BLOCKS)
                 && (32'(in_element) < HALF);
    wr.full_we = in_acc && (in_kind == K_WORD) && row_ok_in && (32'(in_element) < MAX_DIM);
    wr.slot    = in_hot_slot;
    wr.rank    = in_cold_position;
    wr.data    = in_write_data;
  end

  hcg_store #(
    .RW(RW), .HW(HW), .CW(CW), .FW(FW),
    .MAP_DEPTH(TABLE_ROWS), .HOT_DEPTH(HOT_D), .COLD_DEPTH(CLD_D), .FULL_DEPTH(FUL_D)
  ) u_store (
    .clk        (clk),
    .wr         (wr),
    .map_waddr  (RW'(in_row_index)),
    .hot_waddr  (HW'(32'(in_hot_slot[7:0]) * MAX_DIM + 32'(in_element))),
    .cold_waddr (CW'(32'(in_block_number) * HALF + 32'(in_element))),
    .full_waddr (FW'(32'(in_row_index) * MAX_DIM + 32'(in_element))),
    .map_raddr  (RW'(in_row_index)),
    .hot_raddr  (HW'(32'(map_r) * MAX_DIM + 32'(d_r))),
    .cold_raddr (CW'(32'(quo_r) * HALF + 32'(d_r[5:1]))),
    .full_raddr (FW'(32'(row_r) * MAX_DIM + 32'(d_r))),
    .map_q      (map_q),
    .rank_q     (rank_q),
    .hot_q      (hot_q),
    .cold_q     (cold_q),
    .full_q     (full_q)
  );

  // Map entries of rows beyond the table read as zero
  assign map_eff  = row_ok_r ? map_q : 9'd0;
  assign rank_eff = row_ok_r ? rank_q : 10'd0;
  assign div_t    = {rem_r, quo_r[9]};
  assign blk_ok   = 32'(quo_r) < COLD_BLOCKS;

  // Pick the dequantizer operands
  always_comb begin
    fpu_start = 1'b0;
    fpu_code  = hot_q;
    fpu_scale = hscale_r;
    fpu_off   = hoff_r;
    if (!hot_r) begin
      fpu_code  = {4'b0, d_r[0] ? cold_q[NIB_BITS-1:0] : cold_q[2*NIB_BITS-1:NIB_BITS]};
      fpu_scale = cscale_r;
      fpu_off   = coff_r;
    end
    if (state_r == S_DATA && quant_r) begin
      fpu_start = hot_r ? slot_ok_r : blk_ok;
    end
  end

  hcg_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (fpu_start),
    .code   (fpu_code),
    .scale  (fpu_scale),
    .offset (fpu_off),
    .done   (fpu_done),
    .result (fpu_res)
  );

  // Sequence a gather
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc && in_kind == K_GATHER) state_nxt = S_MAP;
      S_MAP:  state_nxt = S_DIV;
      S_DIV:  if (cnt_r == 4'd9) state_nxt = S_ELEM;
      S_ELEM: state_nxt = S_DATA;
      S_DATA: state_nxt = fpu_start ? S_CALC : S_EMIT;
      S_CALC: if (fpu_done) state_nxt = S_EMIT;
      S_EMIT: if (out_acc) state_nxt = out_last ? S_IDLE : S_ELEM;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the gather context and run the rank divider
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        row_r    <= in_row_index;
        row_ok_r <= row_ok_in;
        quant_r  <= large_r;
        dims_r   <= dims_eff;
        d_r      <= 6'd0;
      end
      S_MAP: begin
        map_r     <= map_eff;
        hot_r     <= !map_eff[8];
        slot_ok_r <= !map_eff[8] && (32'(map_eff) < HOT_ROWS);
        rem_r     <= 10'd0;
        quo_r     <= rank_eff;
        cnt_r     <= 4'd0;
      end
      S_DIV: begin
        if (div_t >= rpb_eff) begin
          rem_r <= 10'(div_t - rpb_eff);
          quo_r <= {quo_r[8:0], 1'b1};
        end else begin
          rem_r <= div_t[9:0];
          quo_r <= {quo_r[8:0], 1'b0};
        end
        cnt_r <= cnt_r + 4'd1;
      end
      S_DATA: begin
        if (!quant_r) begin
          val_r <= row_ok_r ? full_q : 32'd0;
        end else begin
          val_r <= 32'd0;
        end
      end
      S_CALC: if (fpu_done) val_r <= fpu_res;
      S_EMIT: if (out_acc) d_r <= d_r + 6'd1;
      default: ;
    endcase
  end

  assign out_element_value  = val_r;
  assign out_element_number = d_r;
  assign out_last           = ({1'b0, d_r} + 7'd1) == dims_r;
  assign out_source         = !quant_r ? SRC_COPY : hot_r ? SRC_HOT : blk_ok ? SRC_COLD
                                                                   : SRC_RANGE;

`ifndef NO_ASSERTIONS
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_last |=> in_ready)
    else $error("gather did not return to idle after its last item");
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_last |=> out_element_number == $past(out_element_number) + 6'd1)
    else $error("dimension index did not advance by one");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    fpu_done |-> state_r == S_CALC)
    else $error("dequantizer result arrived outside calculation");
  a_gather: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_kind == K_GATHER |=> !in_ready && !out_valid)
    else $error("gather item did not start the map read");
`endif

endmodule

`default_nettype wire

/* rtl/core/hcg_store.sv */
// ----------------------------------------------------------------------------
// hcg_store
// Embedding stores: row map, hot bytes, cold block bytes and fp32 words,
// each with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hcg_store #(
  parameter int RW = 10,
  parameter int HW = 14,
  parameter int CW = 11,
  parameter int FW = 16,
  parameter int MAP_DEPTH  = 1024,
  parameter int HOT_DEPTH  = 16384,
  parameter int COLD_DEPTH = 2048,
  parameter int FULL_DEPTH = 65536
) (
  input  wire              clk,
  input  hcg_pkg::wr_t     wr,
  input  wire  [RW-1:0]    map_waddr,
  input  wire  [HW-1:0]    hot_waddr,
  input  wire  [CW-1:0]    cold_waddr,
  input  wire  [FW-1:0]    full_waddr,
  input  wire  [RW-1:0]    map_raddr,
  input  wire  [HW-1:0]    hot_raddr,
  input  wire  [CW-1:0]    cold_raddr,
  input  wire  [FW-1:0]    full_raddr,
  output logic [8:0]       map_q,
  output logic [9:0]       rank_q,
  output logic [7:0]       hot_q,
  output logic [7:0]       cold_q,
  output logic [31:0]      full_q
);
  import hcg_pkg::*;

  logic [18:0] map_mem  [MAP_DEPTH];
  logic [7:0]  hot_mem  [HOT_DEPTH];
  logic [7:0]  cold_mem [COLD_DEPTH];
  logic [31:0] full_mem [FULL_DEPTH];

  // Row map: hot slot and cold rank side by side
  always_ff @(posedge clk) begin
    if (wr.map_we) begin
      map_mem[map_waddr] <= {wr.slot, wr.rank};
    end
    {map_q, rank_q} <= map_mem[map_raddr];
  end

  // Hot row bytes
  always_ff @(posedge clk) begin
    if (wr.hot_we) begin
      hot_mem[hot_waddr] <= wr.data[7:0];
    end
    hot_q <= hot_mem[hot_raddr];
  end

  // Cold block bytes
  always_ff @(posedge clk) begin
    if (wr.cold_we) begin
      cold_mem[cold_waddr] <= wr.data[7:0];
    end
    cold_q <= cold_mem[cold_raddr];
  end

  // Full fp32 rows
  always_ff @(posedge clk) begin
    if (wr.full_we) begin
      full_mem[full_waddr] <= wr.data;
    end
    full_q <= full_mem[full_raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/hcg_fpu.sv */
// ----------------------------------------------------------------------------
// hcg_fpu
// Nine-stage dequantizer: code * scale, then + offset, each rounded to
// single precision (nearest even), NaN results made canonical.
// ----------------------------------------------------------------------------
`default_nettype none

module hcg_fpu (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire  [7:0]  code,
  input  wire  [31:0] scale,
  input  wire  [31:0] offset,
  output logic        done,
  output logic [31:0] result
);
  import hcg_pkg::*;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  // Leading zero count of a 32-bit word
  function automatic logic [4:0] lzc32(input logic [31:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 5'(31 - i);
    end
    return n;
  endfunction

  // Round a normalized significand (bit 31 set) at biased exponent r
  function automatic logic [31:0] pack(input logic sgn, input logic signed [9:0] r,
                                       input logic [31:0] n);
    logic [63:0] x;
    logic [23:0] m;
    logic [7:0]  ef;
    logic        g;
    logic        st;
    logic [30:0] mag;
    x = '0;
    if (r >= 10'sd255) begin
      return {sgn, 8'hFF, 23'b0};
    end
    if (r >= 10'sd1) begin
      m  = n[31:8];
      g  = n[7];
      st = |n[6:0];
      ef = r[7:0];
    end else begin
      x  = {n, 32'b0} >> (10'sd1 - r);
      m  = x[63:40];
      g  = x[39];
      st = |x[38:0];
      ef = 8'd0;
    end
    mag = {ef, m[22:0]} + 31'(g & (st | m[0]));
    return {sgn, mag};
  endfunction

  logic [8:0] v_r;

  // Stage 1: integer product
  logic [31:0] p1_p_r;
  logic [7:0]  p1_e_r;
  logic        p1_s_r, p1_spv_r;
  logic [31:0] p1_sp_r, p1_off_r;
  // Stage 2: leading zeros
  logic [31:0] p2_p_r;
  logic [7:0]  p2_e_r;
  logic [4:0]  p2_lz_r;
  logic        p2_s_r, p2_spv_r;
  logic [31:0] p2_sp_r, p2_off_r;
  // Stage 3: normalized product
  logic [31:0] p3_n_r;
  logic signed [9:0] p3_r_r;
  logic        p3_s_r, p3_spv_r;
  logic [31:0] p3_sp_r, p3_off_r;
  // Stage 4: rounded product
  logic [31:0] p4_a_r, p4_off_r;
  // Stage 5: aligned operands
  logic [26:0] a5_x_r, a5_y_r;
  logic        a5_sub_r, a5_s_r, a5_zs_r, a5_spv_r;
  logic [7:0]  a5_e_r;
  logic [31:0] a5_sp_r;
  // Stage 6: sum
  logic [27:0] a6_s_r;
  logic        a6_s_sgn_r, a6_zs_r, a6_spv_r;
  logic [7:0]  a6_e_r;
  logic [31:0] a6_sp_r;
  // Stage 7: leading zeros of sum
  logic [27:0] a7_s_r;
  logic [4:0]  a7_lz_r;
  logic        a7_sgn_r, a7_zs_r, a7_spv_r, a7_zero_r;
  logic [7:0]  a7_e_r;
  logic [31:0] a7_sp_r;
  // Stage 8: normalized sum
  logic [31:0] a8_n_r;
  logic signed [9:0] a8_r_r;
  logic        a8_sgn_r, a8_zs_r, a8_spv_r, a8_zero_r;
  logic [31:0] a8_sp_r;
  // Stage 9: result
  logic [31:0] res_r;

  // Advance the valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[7:0], start};
    end
  end

  // Stage 1 logic
  logic [7:0]  s1_e;
  logic [23:0] s1_m;
  logic        s1_nan, s1_inf;
  logic [31:0] s1_p;
  always_comb begin
    s1_nan = (scale[30:23] == 8'hFF) && (scale[22:0] != 23'd0);
    s1_inf = (scale[30:23] == 8'hFF) && (scale[22:0] == 23'd0);
    s1_m   = {scale[30:23] != 8'd0, scale[22:0]};
    s1_e   = (scale[30:23] == 8'd0) ? 8'd1 : scale[30:23];
    s1_p   = {24'b0, code} * {8'b0, s1_m};
  end

  always_ff @(posedge clk) begin
    p1_p_r   <= s1_p;
    p1_e_r   <= s1_e;
    p1_s_r   <= scale[31];
    p1_off_r <= offset;
    p1_spv_r <= s1_nan || s1_inf || (s1_p == 32'd0);
    if (s1_nan || (s1_inf && code == 8'd0)) begin
      p1_sp_r <= QNAN;
    end else if (s1_inf) begin
      p1_sp_r <= {scale[31], 8'hFF, 23'b0};
    end else begin
      p1_sp_r <= {scale[31], 31'b0};
    end
  end

  // Stage 2: count leading zeros
  always_ff @(posedge clk) begin
    p2_p_r   <= p1_p_r;
    p2_e_r   <= p1_e_r;
    p2_lz_r  <= lzc32(p1_p_r);
    p2_s_r   <= p1_s_r;
    p2_spv_r <= p1_spv_r;
    p2_sp_r  <= p1_sp_r;
    p2_off_r <= p1_off_r;
  end

  // Stage 3: normalize product
  always_ff @(posedge clk) begin
    p3_n_r   <= p2_p_r << p2_lz_r;
    p3_r_r   <= $signed({2'b0, p2_e_r}) + 10'sd8 - $signed({5'b0, p2_lz_r});
    p3_s_r   <= p2_s_r;
    p3_spv_r <= p2_spv_r;
    p3_sp_r  <= p2_sp_r;
    p3_off_r <= p2_off_r;
  end

  // Stage 4: round product
  always_ff @(posedge clk) begin
    p4_a_r   <= p3_spv_r ? p3_sp_r : pack(p3_s_r, p3_r_r, p3_n_r);
    p4_off_r <= p3_off_r;
  end

  // Stage 5: order by magnitude and align the smaller operand
  logic        a_nan, b_nan, a_inf, b_inf, swp;
  logic [31:0] xo, yo;
  logic [7:0]  ex, ey, dd;
  logic [4:0]  dc;
  logic [53:0] w;
  always_comb begin
    a_nan = (p4_a_r[30:23] == 8'hFF) && (p4_a_r[22:0] != 23'd0);
    b_nan = (p4_off_r[30:23] == 8'hFF) && (p4_off_r[22:0] != 23'd0);
    a_inf = (p4_a_r[30:23] == 8'hFF) && (p4_a_r[22:0] == 23'd0);
    b_inf = (p4_off_r[30:23] == 8'hFF) && (p4_off_r[22:0] == 23'd0);
    swp   = p4_a_r[30:0] < p4_off_r[30:0];
    xo    = swp ? p4_off_r : p4_a_r;
    yo    = swp ? p4_a_r : p4_off_r;
    ex    = (xo[30:23] == 8'd0) ? 8'd1 : xo[30:23];
    ey    = (yo[30:23] == 8'd0) ? 8'd1 : yo[30:23];
    dd    = ex - ey;
    dc    = (dd > 8'd30) ? 5'd30 : dd[4:0];
    w     = {yo[30:23] != 8'd0, yo[22:0], 3'b0, 27'b0} >> dc;
  end

  always_ff @(posedge clk) begin
    a5_x_r   <= {xo[30:23] != 8'd0, xo[22:0], 3'b0};
    a5_y_r   <= w[53:27] | {26'b0, |w[26:0]};
    a5_sub_r <= xo[31] ^ yo[31];
    a5_s_r   <= xo[31];
    a5_zs_r  <= p4_a_r[31] & p4_off_r[31];
    a5_e_r   <= ex;
    a5_spv_r <= a_nan || b_nan || a_inf || b_inf;
    if (a_nan || b_nan || (a_inf && b_inf && (p4_a_r[31] != p4_off_r[31]))) begin
      a5_sp_r <= QNAN;
    end else if (a_inf) begin
      a5_sp_r <= p4_a_r;
    end else begin
      a5_sp_r <= p4_off_r;
    end
  end

  // Stage 6: add or subtract
  always_ff @(posedge clk) begin
    a6_s_r     <= a5_sub_r ? ({1'b0, a5_x_r} - {1'b0, a5_y_r})
                           : ({1'b0, a5_x_r} + {1'b0, a5_y_r});
    a6_s_sgn_r <= a5_s_r;
    a6_zs_r    <= a5_zs_r;
    a6_e_r     <= a5_e_r;
    a6_spv_r   <= a5_spv_r;
    a6_sp_r    <= a5_sp_r;
  end

  // Stage 7: count leading zeros of the sum
  always_ff @(posedge clk) begin
    a7_s_r    <= a6_s_r;
    a7_lz_r   <= lzc32({a6_s_r, 4'b0});
    a7_zero_r <= (a6_s_r == 28'd0);
    a7_sgn_r  <= a6_s_sgn_r;
    a7_zs_r   <= a6_zs_r;
    a7_e_r    <= a6_e_r;
    a7_spv_r  <= a6_spv_r;
    a7_sp_r   <= a6_sp_r;
  end

  // Stage 8: normalize sum
  always_ff @(posedge clk) begin
    a8_n_r    <= {a7_s_r, 4'b0} << a7_lz_r;
    a8_r_r    <= $signed({2'b0, a7_e_r}) + 10'sd1 - $signed({5'b0, a7_lz_r});
    a8_zero_r <= a7_zero_r;
    a8_sgn_r  <= a7_sgn_r;
    a8_zs_r   <= a7_zs_r;
    a8_spv_r  <= a7_spv_r;
    a8_sp_r   <= a7_sp_r;
  end

  // Stage 9: round sum, select special results
  always_ff @(posedge clk) begin
    if (a8_spv_r) begin
      res_r <= a8_sp_r;
    end else if (a8_zero_r) begin
      res_r <= {a8_zs_r, 31'b0};
    end else begin
      res_r <= pack(a8_sgn_r, a8_r_r, a8_n_r);
    end
  end

  assign done   = v_r[8];
  assign result = res_r;

endmodule

`default_nettype wire
